[rtl/sliding_window_median_macros.svh]
// Assertion macros used by the sliding window median checker.
`ifndef SLIDING_WINDOW_MEDIAN_MACROS_SVH
`define SLIDING_WINDOW_MEDIAN_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SWM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SWM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/swm_pkg.sv]
// Package with the types and constants of the sliding window median filter.
package swm_pkg;

    localparam int MAX_WINDOW_DEF = 64;
    localparam int SAMPLE_W       = 16;
    localparam int LEN_W          = 7;
    localparam logic [LEN_W-1:0] LEN_RESET = 7'd9;
    // Number of cells merged by one first-level group of the median select.
    localparam int GROUP          = 8;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    // Control broadcast from the sequencer to every cell of the sorted chain.
    typedef struct packed {
        logic clear;
        logic update;
        logic del;
    } swm_ctrl_t;

    // Left-to-right link: the entry after removal and its compare result.
    typedef struct packed {
        sample_t value;
        logic    valid;
        logic    le;
    } swm_link_t;

    // Stored contents of one cell.
    typedef struct packed {
        sample_t value;
        logic    valid;
    } swm_entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_GATHER,
        ST_RESULT
    } swm_state_t;

endpackage

[rtl/swm_cell.sv]
// One cell of the sorted sample chain: removes, shifts and inserts in one update.
module swm_cell
    import swm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  swm_ctrl_t  ctrl,
    input  sample_t    new_sample,
    input  sample_t    old_sample,
    input  swm_link_t  from_left,
    input  swm_entry_t from_right,
    output swm_link_t  to_right,
    output swm_entry_t entry
);

    sample_t    value_reg;
    sample_t    value_next;
    logic       valid_reg;
    logic       valid_next;
    logic       upper_equal;
    logic       take_right;
    swm_entry_t removed;
    logic       le;

    // The removed entry is the topmost copy of the old sample; every valid
    // cell at or above it takes the entry of its right neighbor.
    always_comb
    begin
        upper_equal = from_right.valid && ($signed(from_right.value) == $signed(old_sample));
        take_right  = ctrl.del && valid_reg &&
                      (($signed(value_reg) > $signed(old_sample)) ||
                       (($signed(value_reg) == $signed(old_sample)) && !upper_equal));
        removed     = take_right ? from_right : swm_entry_t'{value: value_reg, valid: valid_reg};
        le          = removed.valid && ($signed(removed.value) <= $signed(new_sample));
    end

    // Insertion: keep entries not above the new sample, place the new sample
    // at the boundary, shift the rest up by one.
    always_comb
    begin
        to_right = swm_link_t'{value: removed.value, valid: removed.valid, le: le};
        if (le)
        begin
            value_next = removed.value;
        end
        else if (from_left.le)
        begin
            value_next = new_sample;
        end
        else
        begin
            value_next = from_left.value;
        end
        valid_next = le || from_left.le || from_left.valid;
    end

    // Valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.update)
        begin
            valid_reg <= valid_next;
        end
    end

    // Sample value.
    always_ff @(posedge clk)
    begin
        if (ctrl.update)
        begin
            value_reg <= value_next;
        end
    end

    assign entry = swm_entry_t'{value: value_reg, valid: valid_reg};

endmodule

[rtl/sliding_window_median.sv]
// Top level of the sliding window median filter.
//
//  Channel  | Handshake                | Payload
//  ---------+--------------------------+-----------------------------
//  sample   | sample_valid/sample_stall| sample
//  result   | result_valid/result_stall| median_value, window_full
//  config   | cfg_valid/cfg_ready      | cfg_data (window_length)
//
// An accepted request reaches the output register through one update of the sorted
// cell chain, the first level of the median select, and the final select with the
// middle-pair average; the oldest sample is read from the ring beforehand. A new
// request is taken only once the sequencer is idle again after the result is loaded;
// a stalled output register holds the sequencer in its last step.
// Reset clears the cell valid bits, the fill count and the ring position.
module sliding_window_median
    import swm_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sample_valid,
    output logic                sample_stall,
    input  logic signed [15:0]  sample,
    output logic                result_valid,
    input  logic                result_stall,
    output logic signed [15:0]  median_value,
    output logic                window_full,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [LEN_W-1:0]    cfg_data
);

    localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
    localparam int NGRP  = (MAX_WINDOW + GROUP - 1) / GROUP;

    swm_state_t       state_reg;
    swm_state_t       state_next;
    logic [LEN_W-1:0] len_reg;
    logic [IDX_W-1:0] pos_reg;
    logic [IDX_W-1:0] pos_next;
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic             full_reg;
    logic             full_next;
    sample_t          sample_reg;
    sample_t          old_reg;
    sample_t          ring [MAX_WINDOW];
    sample_t          grp_hi_reg [NGRP];
    sample_t          grp_lo_reg [NGRP];
    sample_t          grp_hi_next [NGRP];
    sample_t          grp_lo_next [NGRP];
    logic             result_valid_reg;
    sample_t          median_reg;
    logic             window_full_reg;

    logic             in_accept;
    logic             cfg_write;
    logic             load_out;
    logic [CMP_W-1:0] len_ext;
    logic [CMP_W-1:0] act_len_cmp;
    logic [CNT_W-1:0] act_len;
    logic             full_before;
    logic [CNT_W:0]   fill_plus;
    logic [CNT_W-1:0] pos_plus;
    logic [IDX_W-1:0] hi_idx;
    logic [IDX_W-1:0] lo_idx;
    logic [MAX_WINDOW-1:0] hi_sel;
    logic [MAX_WINDOW-1:0] lo_sel;
    sample_t          hi_val;
    sample_t          lo_val;
    logic [SAMPLE_W:0] pair_sum;
    logic [SAMPLE_W:0] pair_adj;
    sample_t          median_calc;
    swm_ctrl_t        ctrl;

    swm_link_t        link [MAX_WINDOW];
    swm_link_t        left_in [MAX_WINDOW];
    swm_entry_t       cell_entry [MAX_WINDOW];
    swm_entry_t       right_in [MAX_WINDOW];

    // Handshakes.
    assign in_accept    = sample_valid && !sample_stall;
    assign cfg_write    = cfg_valid && cfg_ready;
    assign cfg_ready    = (state_reg == ST_IDLE);
    assign sample_stall = (state_reg != ST_IDLE) || cfg_valid;

    // Active window length: zero acts as one, above capacity acts as capacity.
    always_comb
    begin
        len_ext = CMP_W'(len_reg);
        if (len_ext == '0)
        begin
            act_len_cmp = CMP_W'(1);
        end
        else if (len_ext > CMP_W'(MAX_WINDOW))
        begin
            act_len_cmp = CMP_W'(MAX_WINDOW);
        end
        else
        begin
            act_len_cmp = len_ext;
        end
        act_len = act_len_cmp[CNT_W-1:0];
    end

    // Fill count and ring position for the item in the update step.
    always_comb
    begin
        full_before = (fill_reg >= act_len);
        fill_plus   = (CNT_W + 1)'(fill_reg) + (CNT_W + 1)'(1);
        fill_next   = full_before ? fill_reg : fill_plus[CNT_W-1:0];
        full_next   = full_before || (fill_plus >= (CNT_W + 1)'(act_len));
        pos_plus    = CNT_W'(pos_reg) + CNT_W'(1);
        pos_next    = (pos_plus >= act_len) ? '0 : pos_plus[IDX_W-1:0];
    end

    // Sequencer: next state and step enables.
    always_comb
    begin
        state_next = state_reg;
        load_out   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = ST_GATHER;
            end
            ST_GATHER:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            len_reg   <= LEN_RESET;
            pos_reg   <= '0;
            fill_reg  <= '0;
            full_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                len_reg  <= cfg_data;
                pos_reg  <= '0;
                fill_reg <= '0;
            end
            else if (state_reg == ST_UPDATE)
            begin
                pos_reg  <= pos_next;
                fill_reg <= fill_next;
                full_reg <= full_next;
            end
        end
    end

    // Captured sample.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            sample_reg <= sample;
        end
    end

    // Arrival-order ring: the oldest sample is read ahead of every request.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_UPDATE)
        begin
            ring[pos_reg] <= sample_reg;
        end
        old_reg <= ring[pos_reg];
    end

    // Sorted chain of cells.
    assign ctrl = swm_ctrl_t'{
        clear:  cfg_write,
        update: (state_reg == ST_UPDATE),
        del:    full_before
    };

    for (genvar i = 0; i < MAX_WINDOW; i++)
    begin : g_cell
        if (i == 0)
        begin : g_first
            assign left_in[i] = swm_link_t'{value: '0, valid: 1'b0, le: 1'b1};
        end
        else
        begin : g_inner_left
            assign left_in[i] = link[i-1];
        end

        if (i == MAX_WINDOW - 1)
        begin : g_last
            assign right_in[i] = swm_entry_t'{value: '0, valid: 1'b0};
        end
        else
        begin : g_inner_right
            assign right_in[i] = cell_entry[i+1];
        end

        swm_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .new_sample (sample_reg),
            .old_sample (old_reg),
            .from_left  (left_in[i]),
            .from_right (right_in[i]),
            .to_right   (link[i]),
            .entry      (cell_entry[i])
        );
    end

    // Middle positions: one cell for an odd length, a pair for an even one.
    always_comb
    begin
        hi_idx = IDX_W'(act_len >> 1);
        lo_idx = act_len[0] ? hi_idx : (hi_idx - IDX_W'(1));
        for (int i = 0; i < MAX_WINDOW; i++)
        begin
            hi_sel[i] = (hi_idx == IDX_W'(i));
            lo_sel[i] = (lo_idx == IDX_W'(i));
        end
    end

    // First level of the median select: one merge per group of cells.
    always_comb
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            grp_hi_next[g] = '0;
            grp_lo_next[g] = '0;
            for (int k = 0; k < GROUP; k++)
            begin
                if (g * GROUP + k < MAX_WINDOW)
                begin
                    if (hi_sel[g * GROUP + k])
                    begin
                        grp_hi_next[g] = grp_hi_next[g] | cell_entry[g * GROUP + k].value;
                    end
                    if (lo_sel[g * GROUP + k])
                    begin
                        grp_lo_next[g] = grp_lo_next[g] | cell_entry[g * GROUP + k].value;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_GATHER)
        begin
            for (int g = 0; g < NGRP; g++)
            begin
                grp_hi_reg[g] <= grp_hi_next[g];
                grp_lo_reg[g] <= grp_lo_next[g];
            end
        end
    end

    // Final select and middle-pair mean, truncated toward zero; new sample until full.
    always_comb
    begin
        hi_val = '0;
        lo_val = '0;
        for (int g = 0; g < NGRP; g++)
        begin
            hi_val = hi_val | grp_hi_reg[g];
            lo_val = lo_val | grp_lo_reg[g];
        end
        pair_sum    = {hi_val[SAMPLE_W-1], hi_val} + {lo_val[SAMPLE_W-1], lo_val};
        pair_adj    = pair_sum + (SAMPLE_W + 1)'(pair_sum[SAMPLE_W]);
        median_calc = full_reg ? sample_t'(pair_adj[SAMPLE_W:1]) : sample_reg;
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            median_reg      <= median_calc;
            window_full_reg <= full_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign median_value = median_reg;
    assign window_full  = window_full_reg;

endmodule

[rtl/swm_checker.sv]
// Port-level checks of the sliding window median filter and their binding.
`include "sliding_window_median_macros.svh"

module swm_checker
    import swm_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               sample_valid,
    input logic               sample_stall,
    input logic               result_valid,
    input logic               result_stall,
    input logic signed [15:0] median_value,
    input logic               window_full,
    input logic               cfg_valid,
    input logic               cfg_ready
);

    // A stalled result keeps its payload.
    `SWM_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && result_stall, result_valid && $stable(median_value) && $stable(window_full), "stalled result changed")

    // An accepted request keeps the input side stalled through the update, gather and result steps.
    `SWM_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, sample_valid && !sample_stall, sample_stall ##1 sample_stall ##1 sample_stall, "input accepted during item processing")

    // Configuration is refused while a request is in flight.
    `SWM_ASSERT_NEXT(a_cfg_blocked, clk, rst_n, sample_valid && !sample_stall, !cfg_ready, "config port open while busy")

    // No sample is accepted together with a configuration write.
    `SWM_ASSERT_SAME(a_cfg_idle, clk, rst_n, cfg_valid && cfg_ready, sample_stall, "sample accepted together with config write")

endmodule

bind sliding_window_median swm_checker u_swm_checker (.*);

[tb/sv/testbench.sv]
// Self-checking testbench for the sliding window median filter.
`timescale 1ns / 1ps

module testbench;
    import swm_pkg::*;

    localparam int IDLE_MAX      = 6;
    localparam int DRAIN_CYCLES  = 8;
    localparam int QUIET_LIMIT   = 2000;
    localparam int HOLD_OFF_LEN  = 300;
    localparam int REPORT_LIMIT  = 10;

    typedef struct {
        sample_t median;
        logic    full;
    } median_result_t;

    logic             clk;
    logic             rst_n;
    logic             sample_valid;
    logic             sample_stall;
    sample_t          sample;
    logic             result_valid;
    logic             result_stall;
    sample_t          median_value;
    logic             window_full;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [LEN_W-1:0] cfg_data;

    // Shadow of the filter: window contents in arrival order and in value order.
    sample_t          arrival_ring [MAX_WINDOW_DEF];
    sample_t          sorted_window [MAX_WINDOW_DEF];
    int unsigned      ring_slot;
    int unsigned      held_count;
    logic [LEN_W-1:0] window_length_setting;

    median_result_t   median_expected[$];

    // Run bookkeeping.
    int  mismatches;
    int  failures;
    int  samples_sent;
    int  results_checked;
    int  settings_written;
    int  quiet_cycles;
    int  hold_off_request;
    bit  idling_on;

    sliding_window_median dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .median_value (median_value),
        .window_full  (window_full),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    // Free-running clock, 12 ns period.
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Advances the shadow window by one sample and returns the expected output.
    task automatic advance_median_window(input sample_t new_sample, output median_result_t res);
        int unsigned span;
        int unsigned pos;
        int unsigned last;
        sample_t     leaving;
        int          pair_sum;
        span = 32'(window_length_setting);
        if (span == 0)
            span = 1;
        if (span > MAX_WINDOW_DEF)
            span = MAX_WINDOW_DEF;
        if (ring_slot >= span)
            ring_slot = 0;
        if (held_count > span)
            held_count = span;

        // Once full, the oldest sample leaves the value order first.
        if (held_count >= span)
        begin
            leaving = arrival_ring[ring_slot];
            pos = 0;
            while (pos < span && sorted_window[pos] != leaving)
                pos++;
            for (; pos + 1 < span; pos++)
                sorted_window[pos] = sorted_window[pos + 1];
            last = span - 1;
        end
        else
        begin
            last = held_count;
            held_count++;
        end

        // Insertion into the ascending list of the remaining entries.
        pos = last;
        while (pos > 0 && sorted_window[pos - 1] > new_sample)
        begin
            sorted_window[pos] = sorted_window[pos - 1];
            pos--;
        end
        sorted_window[pos] = new_sample;

        arrival_ring[ring_slot] = new_sample;
        ring_slot++;
        if (ring_slot >= span)
            ring_slot = 0;

        res.full = (held_count >= span);
        if (!res.full)
            res.median = new_sample;
        else if (span % 2 == 1)
            res.median = sorted_window[span / 2];
        else
        begin
            pair_sum = int'(sorted_window[span / 2 - 1]) + int'(sorted_window[span / 2]);
            res.median = sample_t'(pair_sum / 2);
        end
    endtask

    // Predicts every accepted request and follows register writes.
    always @(posedge clk)
    begin
        median_result_t res;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                window_length_setting = cfg_data;
                ring_slot = 0;
                held_count = 0;
            end
            if (sample_valid && !sample_stall)
            begin
                advance_median_window(sample, res);
                median_expected.push_back(res);
            end
        end
    end

    // Compares each accepted result with the oldest prediction.
    always @(posedge clk)
    begin
        median_result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            results_checked++;
            if (median_expected.size() == 0)
            begin
                failures++;
                if (mismatches < REPORT_LIMIT)
                    $display("result %0d arrived with no prediction pending: median %0d full %0b",
                             results_checked, median_value, window_full);
                mismatches++;
            end
            else
            begin
                want = median_expected.pop_front();
                if (median_value !== want.median || window_full !== want.full)
                begin
                    failures++;
                    if (mismatches < REPORT_LIMIT)
                        $display("result %0d mismatch: expected median %0d full %0b, got median %0d full %0b",
                                 results_checked, want.median, want.full, median_value, window_full);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: ends the run if no handshake completes for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((sample_valid && !sample_stall) || (result_valid && !result_stall) ||
                (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("watchdog expired after %0d quiet cycles, %0d predictions pending",
                         quiet_cycles, median_expected.size());
                $display("testbench: FAIL");
                $finish;
            end
        end
    end

    // Result side: random stall before each result, plus an optional long hold-off.
    initial
    begin
        int stall_len;
        result_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_off_request > 0)
            begin
                result_stall <= 1'b1;
                repeat (hold_off_request) @(negedge clk);
                hold_off_request = 0;
            end
            else
            begin
                stall_len = idling_on ? $urandom_range(0, IDLE_MAX) : 0;
                if (stall_len > 0)
                begin
                    result_stall <= 1'b1;
                    repeat (stall_len) @(negedge clk);
                end
            end
            result_stall <= 1'b0;
            do
                @(posedge clk);
            while (!(result_valid && !result_stall));
            @(negedge clk);
        end
    end

    // Offers one sample after a random gap and returns once it is accepted.
    task automatic send_sample(input sample_t value);
        int gap;
        gap = idling_on ? $urandom_range(0, IDLE_MAX) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_valid <= 1'b1;
        sample <= value;
        do
            @(posedge clk);
        while (sample_stall);
        samples_sent++;
    endtask

    // Drops the request, waits for every result and lets the pipeline settle.
    task automatic drain_results();
        @(negedge clk);
        sample_valid <= 1'b0;
        while (median_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Writes the window length while the filter is idle.
    task automatic set_window_length(input logic [LEN_W-1:0] len);
        drain_results();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= len;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        settings_written++;
    endtask

    // Mixes full-range values with clustered small values and the extremes.
    function automatic sample_t random_sample();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 5)
            return sample_t'($urandom);
        else if (pick < 8)
            return sample_t'(int'($urandom_range(0, 8)) - 4);
        else if (pick == 8)
            return $urandom_range(0, 1) ? sample_t'(16'sh7FFF) : sample_t'(16'sh8000);
        else
            return sample_t'(int'($urandom_range(0, 6)) - 3 + ($urandom_range(0, 1) ? 32767 : -32768));
    endfunction

    // Reset length: filling passes samples through, the ninth gets the median.
    task automatic test_default_length();
        sample_t fill_values [11];
        fill_values = '{16'sh8000, 16'sh7FFF, 16'sd0, -16'sd1, 16'sd1, 16'sh7FFF,
                        16'sh8000, 16'sd100, -16'sd100, 16'sh7FFF, 16'sd0};
        foreach (fill_values[i])
            send_sample(fill_values[i]);
    endtask

    // Even length: mean of the middle pair, truncated toward zero, no overflow.
    task automatic test_even_length();
        set_window_length(7'd2);
        send_sample(-16'sd3);
        send_sample(-16'sd2);
        send_sample(16'sh7FFF);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sh8000);
    endtask

    // Lengths zero and one both pass every sample through as a full window.
    task automatic test_shortest_lengths();
        set_window_length(7'd0);
        send_sample(16'sh8000);
        send_sample(16'sd5);
        set_window_length(7'd1);
        send_sample(16'sh7FFF);
        send_sample(-16'sd5);
    endtask

    // Long receiver hold-off while samples keep coming, so the input stalls.
    task automatic test_output_backpressure();
        set_window_length(7'd5);
        idling_on = 1'b0;
        hold_off_request = HOLD_OFF_LEN;
        repeat (30) send_sample(random_sample());
        idling_on = 1'b1;
    endtask

    // Random phases over many lengths, the extremes and out-of-range ones among them.
    task automatic test_random_windows();
        logic [LEN_W-1:0] lengths [14];
        lengths = '{7'd3, 7'd64, 7'd65, 7'd127, 7'd1, 7'd0, 7'd2, 7'd4, 7'd9,
                    7'd0, 7'd0, 7'd0, 7'd0, 7'd63};
        for (int k = 9; k < 13; k++)
            lengths[k] = LEN_W'($urandom_range(1, 127));
        foreach (lengths[k])
        begin
            set_window_length(lengths[k]);
            idling_on = (k % 4 != 3);
            repeat (140) send_sample(random_sample());
        end
        idling_on = 1'b1;
    endtask

    // Reset, the tests in turn, then the verdict.
    initial
    begin
        rst_n <= 1'b0;
        sample_valid <= 1'b0;
        sample <= '0;
        cfg_valid <= 1'b0;
        cfg_data <= '0;
        window_length_setting = LEN_RESET;
        ring_slot = 0;
        held_count = 0;
        mismatches = 0;
        failures = 0;
        samples_sent = 0;
        results_checked = 0;
        settings_written = 0;
        quiet_cycles = 0;
        hold_off_request = 0;
        idling_on = 1'b1;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_default_length();
        test_even_length();
        test_shortest_lengths();
        test_output_backpressure();
        test_random_windows();
        drain_results();

        if (median_expected.size() != 0)
            failures++;
        $display("Covered %0d samples and %0d results over %0d length writes,",
                 samples_sent, results_checked, settings_written);
        $display("including lengths 0, 1, 2, 64, above capacity and a long output hold-off.");
        if (failures == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
